/* hdl/efc_pkg.sv */
// Shared types, constants and helper functions of the Euler-angle fly camera.
// Used by every module of the block; depends on nothing.
`default_nettype none

package efc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MOVE_SPEED = 2'd0;
    localparam logic [1:0] CFG_LOOK_SENS  = 2'd1;
    localparam logic [1:0] CFG_CONSTRAIN  = 2'd2;

    // Item commands and move directions
    localparam logic       CMD_MOVE  = 1'b0;
    localparam logic       CMD_LOOK  = 1'b1;
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Angles in Q16.16 degrees, held at 35 bits for intermediate sums
    localparam logic signed [34:0] DEG_90      = 35'sd5898240;
    localparam logic signed [34:0] DEG_180     = 35'sd11796480;
    localparam logic signed [34:0] PITCH_LIM   = 35'sd5832704;
    localparam logic signed [34:0] WRAP_OFFSET = 35'sd3019898880;
    localparam logic [32:0]        DEG_360_U   = 33'd23592960;
    localparam logic signed [24:0] YAW_RESET   = -25'sd5898240;

    // Vectors in Q2.14, CORDIC internals in Q1.30
    localparam logic signed [15:0] VEC_ONE  = 16'sd16384;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam int                 CORDIC_N = 16;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        direction;
        logic [15:0]       delta_time;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } out_item_t;

    // Request to and status from the shared CORDIC unit
    typedef struct packed {
        logic               start;
        logic signed [24:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] sin;
        logic signed [15:0] cos;
    } cordic_rsp_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic signed [16:0] a;
        logic signed [32:0] b;
    } mul_req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_VEL, S_VLAT, S_STEP, S_ACC,
        S_LY, S_LP, S_LSUM, S_WRAP, S_PFIX,
        S_CY, S_CYW, S_CP, S_CPW, S_PMUL, S_PCAP, S_DONE
    } state_t;

    // Arctangent of 2^-i in Q16.16 degrees
    function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
        logic signed [25:0] r;
        unique case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117304;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    // Limit a value to the unit range of Q2.14
    function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd16384)
            r = VEC_ONE;
        else if (v < -36'sd16384)
            r = -VEC_ONE;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/euler_fly_camera_update.sv */
// Fly camera with Euler angles: move and look items update the position and the
// yaw and pitch, and each item returns the position and the unit front, right and
// up vectors of the view basis. One item at a time: a move item steps the position
// on the shared multiplier, a look item updates yaw and pitch and wraps the yaw,
// and the pitch too when it is not clamped; both then take two sixteen-rotation
// CORDIC runs on one shared unit and four basis products on the shared multiplier.
// Each angle wrap has eight steps. The result waits in an output register, and the
// next item is taken meanwhile.
// Depends on efc_pkg, efc_mul and efc_cordic.
`default_nettype none

module euler_fly_camera_update (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire efc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output efc_pkg::out_item_t      out_data
);
    import efc_pkg::*;

    state_t             state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [15:0]        speed_reg, speed_next;
    logic [15:0]        sens_reg, sens_next;
    logic               constrain_reg, constrain_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [24:0] yaw_reg, yaw_next;
    logic signed [24:0] pitch_reg, pitch_next;
    logic signed [15:0] front_reg [3];
    logic signed [15:0] front_next [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] right_next [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] up_next [3];
    logic [31:0]        vel_reg, vel_next;
    logic [1:0]         idx_reg, idx_next;
    logic [32:0]        wrap_reg, wrap_next;
    logic [2:0]         k_reg, k_next;
    logic               wsel_reg, wsel_next;
    logic signed [33:0] psum_reg, psum_next;
    logic signed [15:0] sy_reg, sy_next, cy_reg, cy_next;
    logic signed [15:0] sp_reg, sp_next, cp_reg, cp_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    mul_req_t           mreq;
    logic signed [49:0] mul_p;
    cordic_req_t        creq;
    cordic_rsp_t        crsp;

    logic signed [49:0] step_rnd;
    logic signed [33:0] pos_sum;
    logic signed [34:0] ang_sum;
    logic [32:0]        wrap_lim;
    logic [32:0]        wrap_after;
    logic signed [34:0] ang_out;
    logic signed [49:0] q_rnd;
    logic signed [15:0] q_val;
    logic               sg;

    efc_mul u_mul (
        .clk (clk),
        .req (mreq),
        .p   (mul_p)
    );

    efc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer: next state, datapath control and register updates.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        speed_next     = speed_reg;
        sens_next      = sens_reg;
        constrain_next = constrain_reg;
        pos_next       = pos_reg;
        yaw_next       = yaw_reg;
        pitch_next     = pitch_reg;
        front_next     = front_reg;
        right_next     = right_reg;
        up_next        = up_reg;
        vel_next       = vel_reg;
        idx_next       = idx_reg;
        wrap_next      = wrap_reg;
        k_next         = k_reg;
        wsel_next      = wsel_reg;
        psum_next      = psum_reg;
        sy_next        = sy_reg;
        cy_next        = cy_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mreq           = '0;
        creq.start     = 1'b0;
        creq.angle     = yaw_reg;

        step_rnd   = (mul_p + 50'sd2097152) >>> 22;
        pos_sum    = '0;
        ang_sum    = '0;
        wrap_lim   = DEG_360_U << k_reg;
        wrap_after = (wrap_reg >= wrap_lim) ? (wrap_reg - wrap_lim) : wrap_reg;
        ang_out    = $signed({2'b00, wrap_after}) - DEG_180;
        q_rnd      = (mul_p + 50'sd8192) >>> 14;
        q_val      = clamp_unit(q_rnd[35:0]);
        sg         = (cp_reg >= 0);

        // Configuration writes
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MOVE_SPEED: speed_next     = cfg_data;
                CFG_LOOK_SENS:  sens_next      = cfg_data;
                CFG_CONSTRAIN:  constrain_next = cfg_data[0];
                default:        ;
            endcase
        end

        // The output register empties on a transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = (in_data.cmd == CMD_MOVE) ? S_VEL : S_LY;
                end
            end
            // Velocity is speed times frame time, Q8.24.
            S_VEL:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({1'b0, speed_reg});
                mreq.b     = $signed({17'd0, item_reg.delta_time});
                state_next = S_VLAT;
            end
            S_VLAT:
            begin
                vel_next   = mul_p[31:0];
                idx_next   = '0;
                state_next = S_STEP;
            end
            // One position component per pass: multiply, then add with saturation.
            S_STEP:
            begin
                mreq.en    = 1'b1;
                mreq.a     = (item_reg.direction == DIR_FWD || item_reg.direction == DIR_BACK)
                             ? 17'(front_reg[idx_reg]) : 17'(right_reg[idx_reg]);
                mreq.b     = $signed({1'b0, vel_reg});
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (item_reg.direction == DIR_FWD || item_reg.direction == DIR_RIGHT)
                    pos_sum = 34'(pos_reg[idx_reg]) + step_rnd[33:0];
                else
                    pos_sum = 34'(pos_reg[idx_reg]) - step_rnd[33:0];
                if (pos_sum > 34'sd2147483647)
                    pos_next[idx_reg] = 32'sh7FFFFFFF;
                else if (pos_sum < -34'sd2147483648)
                    pos_next[idx_reg] = 32'sh80000000;
                else
                    pos_next[idx_reg] = pos_sum[31:0];
                if (idx_reg == 2'd2)
                    state_next = S_CY;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_STEP;
                end
            end
            // Look deltas are mouse counts times sensitivity.
            S_LY:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({1'b0, sens_reg});
                mreq.b     = 33'(item_reg.x_offset);
                state_next = S_LP;
            end
            S_LP:
            begin
                mreq.en    = 1'b1;
                mreq.a     = $signed({1'b0, sens_reg});
                mreq.b     = 33'(item_reg.y_offset);
                ang_sum    = 35'(yaw_reg) + mul_p[34:0] + DEG_180 + WRAP_OFFSET;
                wrap_next  = ang_sum[32:0];
                wsel_next  = 1'b0;
                state_next = S_LSUM;
            end
            S_LSUM:
            begin
                psum_next  = 34'(pitch_reg) + mul_p[33:0];
                k_next     = 3'd7;
                state_next = S_WRAP;
            end
            // Reduce modulo 360 degrees by subtracting 360 times 2^k, k from 7 down.
            S_WRAP:
            begin
                wrap_next = wrap_after;
                k_next    = k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    if (!wsel_reg)
                    begin
                        yaw_next   = ang_out[24:0];
                        state_next = S_PFIX;
                    end
                    else
                    begin
                        pitch_next = ang_out[24:0];
                        state_next = S_CY;
                    end
                end
            end
            S_PFIX:
            begin
                if (constrain_reg)
                begin
                    if (35'(psum_reg) > PITCH_LIM)
                        pitch_next = PITCH_LIM[24:0];
                    else if (35'(psum_reg) < -PITCH_LIM)
                        pitch_next = 25'(-PITCH_LIM);
                    else
                        pitch_next = psum_reg[24:0];
                    state_next = S_CY;
                end
                else
                begin
                    ang_sum    = 35'(psum_reg) + DEG_180 + WRAP_OFFSET;
                    wrap_next  = ang_sum[32:0];
                    wsel_next  = 1'b1;
                    k_next     = 3'd7;
                    state_next = S_WRAP;
                end
            end
            // Sine and cosine of yaw, then of pitch.
            S_CY:
            begin
                creq.start = 1'b1;
                creq.angle = yaw_reg;
                state_next = S_CYW;
            end
            S_CYW:
            begin
                if (crsp.done)
                begin
                    sy_next    = crsp.sin;
                    cy_next    = crsp.cos;
                    state_next = S_CP;
                end
            end
            S_CP:
            begin
                creq.start = 1'b1;
                creq.angle = pitch_reg;
                state_next = S_CPW;
            end
            S_CPW:
            begin
                if (crsp.done)
                begin
                    sp_next    = crsp.sin;
                    cp_next    = crsp.cos;
                    idx_next   = '0;
                    state_next = S_PMUL;
                end
            end
            // The four products of the basis, one per pass.
            S_PMUL:
            begin
                mreq.en = 1'b1;
                unique case (idx_reg)
                    2'd0:
                    begin
                        mreq.a = 17'(cy_reg);
                        mreq.b = 33'(cp_reg);
                    end
                    2'd1:
                    begin
                        mreq.a = 17'(sy_reg);
                        mreq.b = 33'(cp_reg);
                    end
                    2'd2:
                    begin
                        mreq.a = -17'(cy_reg);
                        mreq.b = 33'(sp_reg);
                    end
                    default:
                    begin
                        mreq.a = -17'(sy_reg);
                        mreq.b = 33'(sp_reg);
                    end
                endcase
                state_next = S_PCAP;
            end
            S_PCAP:
            begin
                unique case (idx_reg)
                    2'd0:    front_next[0] = q_val;
                    2'd1:    front_next[2] = q_val;
                    2'd2:    up_next[0]    = sg ? q_val : -q_val;
                    default: up_next[2]    = sg ? q_val : -q_val;
                endcase
                if (idx_reg == 2'd3)
                begin
                    front_next[1] = sp_reg;
                    right_next[0] = sg ? -sy_reg : sy_reg;
                    right_next[1] = '0;
                    right_next[2] = sg ? cy_reg : -cy_reg;
                    up_next[1]    = sg ? cp_reg : -cp_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_PMUL;
                end
            end
            // Hand the result over once the output register is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.pos_x   = pos_reg[0];
                    out_data_next.pos_y   = pos_reg[1];
                    out_data_next.pos_z   = pos_reg[2];
                    out_data_next.front_x = front_reg[0];
                    out_data_next.front_y = front_reg[1];
                    out_data_next.front_z = front_reg[2];
                    out_data_next.right_x = right_reg[0];
                    out_data_next.right_y = right_reg[1];
                    out_data_next.right_z = right_reg[2];
                    out_data_next.up_x    = up_reg[0];
                    out_data_next.up_y    = up_reg[1];
                    out_data_next.up_z    = up_reg[2];
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration, camera state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= 16'd640;
            sens_reg      <= 16'd6554;
            constrain_reg <= 1'b1;
            pos_reg       <= '{32'sd0, 32'sd0, 32'sd0};
            yaw_reg       <= YAW_RESET;
            pitch_reg     <= '0;
            front_reg     <= '{16'sd0, 16'sd0, -VEC_ONE};
            right_reg     <= '{VEC_ONE, 16'sd0, 16'sd0};
            up_reg        <= '{16'sd0, VEC_ONE, 16'sd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            speed_reg     <= speed_next;
            sens_reg      <= sens_next;
            constrain_reg <= constrain_next;
            pos_reg       <= pos_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            front_reg     <= front_next;
            right_reg     <= right_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the sequence
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        vel_reg      <= vel_next;
        idx_reg      <= idx_next;
        wrap_reg     <= wrap_next;
        k_reg        <= k_next;
        wsel_reg     <= wsel_next;
        psum_reg     <= psum_next;
        sy_reg       <= sy_next;
        cy_reg       <= cy_next;
        sp_reg       <= sp_next;
        cp_reg       <= cp_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

/* hdl/efc_mul.sv */
// Shared signed multiplier of the fly camera, 17 by 33 bits, registered output.
// Depends on efc_pkg for the request type.
`default_nettype none

module efc_mul (
    input  wire logic                 clk,
    input  wire efc_pkg::mul_req_t    req,
    output logic signed [49:0]        p
);
    import efc_pkg::*;

    logic signed [49:0] p_reg;
    logic signed [49:0] p_next;

    // The product is taken only when a request is issued, and held otherwise.
    always_comb
    begin
        p_next = p_reg;
        if (req.en)
        begin
            p_next = 50'(req.a * req.b);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hdl/efc_cordic.sv */
// Iterative CORDIC sine and cosine unit: one rotation per cycle, sixteen in all.
// Depends on efc_pkg for the arctangent table, constants and handshake types.
`default_nettype none

module efc_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire efc_pkg::cordic_req_t req,
    output efc_pkg::cordic_rsp_t      rsp
);
    import efc_pkg::*;

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic [3:0]         it_reg, it_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               flip_reg, flip_next;

    logic signed [34:0] ang;
    logic signed [33:0] x_sh, y_sh;
    logic signed [33:0] c_rnd, s_rnd;
    logic signed [15:0] c_cl, s_cl;

    // Fold the angle into plus or minus 90 degrees, then rotate towards zero.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        flip_next = flip_reg;
        ang       = 35'(req.angle);
        x_sh      = x_reg >>> it_reg;
        y_sh      = y_reg >>> it_reg;
        if (req.start)
        begin
            x_next    = CORDIC_K;
            y_next    = '0;
            it_next   = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            if (ang > DEG_90)
            begin
                z_next    = 26'(ang - DEG_180);
                flip_next = 1'b1;
            end
            else if (ang < -DEG_90)
            begin
                z_next    = 26'(ang + DEG_180);
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = 26'(ang);
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_deg(it_reg);
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_deg(it_reg);
            end
            it_next = it_reg + 4'd1;
            if (it_reg == 4'(CORDIC_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        it_reg   <= it_next;
        flip_reg <= flip_next;
    end

    // Round half up to Q2.14, limit to the unit range and undo the fold.
    always_comb
    begin
        c_rnd    = (x_reg + 34'sd32768) >>> 16;
        s_rnd    = (y_reg + 34'sd32768) >>> 16;
        c_cl     = clamp_unit(36'(c_rnd));
        s_cl     = clamp_unit(36'(s_rnd));
        rsp.done = done_reg;
        rsp.cos  = flip_reg ? -c_cl : c_cl;
        rsp.sin  = flip_reg ? -s_cl : s_cl;
    end

endmodule

`default_nettype wire

/* hdl/efc_checker.sv */
// Port-level checks of the fly camera, bound to the top level.
// Depends on efc_pkg for the result type.
`default_nettype none

module efc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire efc_pkg::out_item_t out_data
);
    import efc_pkg::*;

    // An accepted item keeps the block busy, so the input is not ready straight after a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again too soon after a transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The front x and up y components stay within the unit range.
    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.front_x <= 16'sd16384 && out_data.front_x >= -16'sd16384
                   && out_data.up_y <= 16'sd16384 && out_data.up_y >= -16'sd16384)
        else $error("vector component outside the unit range");

    // The right vector lies in the horizontal plane.
    a_right_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.right_y == 16'sd0)
        else $error("right vector has a vertical component");

endmodule

bind euler_fly_camera_update efc_checker u_efc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
